// ----- src/gdsrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdsrs_pkg
// Shared types, codes and constants for the gate-driver SPI register sequencer.
// ----------------------------------------------------------------------------
package gdsrs_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CMP_W      = 33;

    localparam logic [15:0] SWITCH_DELAY      = 16'd10;
    localparam logic [15:0] STATUS_STEP_DELAY = 16'd1;
    localparam logic [15:0] POLL_RESET        = 16'd100;

    localparam logic [10:0] DATA_MASK = 11'h7FF;

    localparam int NUM_CTRL = 7;

    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_LAST   = 3'd3;
    localparam logic [2:0] CT_WAIT   = 3'd7;
    localparam logic [2:0] CT_LAST   = 3'd6;
    localparam logic [3:0] CTRL_BASE = 4'd4;

    typedef enum logic [1:0] {
        MODE_POLL    = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_CONFIRM = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PH_INIT    = 3'd0,
        PH_IDLE    = 3'd1,
        PH_STATUS  = 3'd2,
        PH_CONTROL = 3'd3,
        PH_WAIT    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        CFG_HS_GATE      = 3'd0,
        CFG_LS_GATE      = 3'd1,
        CFG_GATE_DRIVE   = 3'd2,
        CFG_IC_OPERATION = 3'd3,
        CFG_SHUNT_AMP    = 3'd4,
        CFG_REGULATOR    = 3'd5,
        CFG_VDS_SENSE    = 3'd6,
        CFG_POLL         = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] spi_reply;
    } in_item_t;

    typedef struct packed {
        logic        access_valid;
        logic [15:0] spi_command;
        logic [3:0]  reg_slot;
        logic [10:0] reg_value;
        logic        drive_enable;
    } out_item_t;

    // chip register address of each slot
    function automatic logic [3:0] slot_address(input logic [3:0] slot);
        logic [3:0] addr;
        unique case (slot)
            4'd0:    addr = 4'd1;
            4'd1:    addr = 4'd2;
            4'd2:    addr = 4'd3;
            4'd3:    addr = 4'd4;
            4'd4:    addr = 4'd5;
            4'd5:    addr = 4'd6;
            4'd6:    addr = 4'd7;
            4'd7:    addr = 4'd9;
            4'd8:    addr = 4'd10;
            4'd9:    addr = 4'd11;
            4'd10:   addr = 4'd12;
            default: addr = 4'd0;
        endcase
        return addr;
    endfunction

    // true once the tick count has reached the limit
    function automatic logic ticks_reached(input logic [TIMER_BITS-1:0] ticks,
                                           input logic [15:0] limit);
        logic [CMP_W-1:0] t;
        logic [CMP_W-1:0] l;
        t = CMP_W'(ticks);
        l = CMP_W'(limit);
        return t >= l;
    endfunction

endpackage

// ----- src/gdsrs_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdsrs_cfg
// Control word registers and poll interval, with a read port for the
// control word of the current write step.
// ----------------------------------------------------------------------------
module gdsrs_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data,
    input  logic [2:0]  rd_index,
    output logic [10:0] ctrl_word,
    output logic [15:0] poll_interval
);

    logic [10:0] word_reg [gdsrs_pkg::NUM_CTRL];
    logic [15:0] poll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gdsrs_pkg::NUM_CTRL; i++)
            begin
                word_reg[i] <= '0;
            end
            poll_reg <= gdsrs_pkg::POLL_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == gdsrs_pkg::CFG_POLL)
            begin
                poll_reg <= wr_data;
            end
            else
            begin
                word_reg[wr_index] <= wr_data[10:0] & gdsrs_pkg::DATA_MASK;
            end
        end
    end

    always_comb
    begin
        if (rd_index == gdsrs_pkg::CT_WAIT)
        begin
            ctrl_word = '0;
        end
        else
        begin
            ctrl_word = word_reg[rd_index];
        end
    end

    assign poll_interval = poll_reg;

endmodule

// ----- src/gdsrs_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdsrs_core
// Sequencer state (phase, sub-steps, shared wait timer, drive enable) and the
// single-pass step logic that forms the frame for each accepted transaction.
// ----------------------------------------------------------------------------
module gdsrs_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  gdsrs_pkg::in_item_t   item,
    input  logic [10:0]           ctrl_word,
    input  logic [15:0]           poll_interval,
    output logic [2:0]            ctrl_index,
    output gdsrs_pkg::out_item_t  result
);

    localparam int TB = gdsrs_pkg::TIMER_BITS;

    gdsrs_pkg::phase_t phase_reg, phase_next;
    gdsrs_pkg::phase_t after_reg, after_next;
    logic [2:0]    st_step_reg, st_step_next;
    logic [2:0]    st_after_reg, st_after_next;
    logic [2:0]    ct_step_reg, ct_step_next;
    logic [2:0]    ct_after_reg, ct_after_next;
    logic [TB-1:0] ticks_reg, ticks_next;
    logic [15:0]   wait_reg, wait_next;
    logic          drive_reg, drive_next;

    logic is_poll;
    logic st_access;
    logic ct_access;
    logic wait_done;

    assign is_poll    = (item.mode == gdsrs_pkg::MODE_POLL);
    assign st_access  = (phase_reg == gdsrs_pkg::PH_STATUS) && (st_step_reg < gdsrs_pkg::ST_WAIT);
    assign ct_access  = (phase_reg == gdsrs_pkg::PH_CONTROL) && (ct_step_reg < gdsrs_pkg::CT_WAIT);
    assign wait_done  = gdsrs_pkg::ticks_reached(ticks_reg, wait_reg);
    assign ctrl_index = ct_step_reg;

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        after_next    = after_reg;
        st_step_next  = st_step_reg;
        st_after_next = st_after_reg;
        ct_step_next  = ct_step_reg;
        ct_after_next = ct_after_reg;
        ticks_next    = ticks_reg;
        wait_next     = wait_reg;
        drive_next    = drive_reg;

        unique case (item.mode)
            gdsrs_pkg::MODE_TICK:
            begin
                if (ticks_reg != {TB{1'b1}})
                begin
                    ticks_next = ticks_reg + TB'(1);
                end
            end
            gdsrs_pkg::MODE_CONFIRM:
            begin
                ticks_next = '0;
                phase_next = gdsrs_pkg::PH_WAIT;
                after_next = gdsrs_pkg::PH_CONTROL;
                wait_next  = gdsrs_pkg::SWITCH_DELAY;
            end
            gdsrs_pkg::MODE_POLL:
            begin
                unique case (phase_reg)
                    gdsrs_pkg::PH_INIT:
                    begin
                        drive_next = 1'b1;
                        ticks_next = '0;
                        phase_next = gdsrs_pkg::PH_WAIT;
                        after_next = gdsrs_pkg::PH_CONTROL;
                        wait_next  = gdsrs_pkg::SWITCH_DELAY;
                    end
                    gdsrs_pkg::PH_IDLE:
                    begin
                        if (gdsrs_pkg::ticks_reached(ticks_reg, poll_interval))
                        begin
                            ticks_next = '0;
                            phase_next = gdsrs_pkg::PH_WAIT;
                            after_next = gdsrs_pkg::PH_STATUS;
                            wait_next  = gdsrs_pkg::SWITCH_DELAY;
                        end
                    end
                    gdsrs_pkg::PH_WAIT:
                    begin
                        if (wait_done)
                        begin
                            phase_next = after_reg;
                        end
                    end
                    gdsrs_pkg::PH_STATUS:
                    begin
                        if (st_step_reg == gdsrs_pkg::ST_WAIT)
                        begin
                            if (wait_done)
                            begin
                                st_step_next = st_after_reg;
                            end
                        end
                        else if (st_access)
                        begin
                            ticks_next = '0;
                            wait_next  = gdsrs_pkg::STATUS_STEP_DELAY;
                            if (st_step_reg == gdsrs_pkg::ST_LAST)
                            begin
                                st_step_next = '0;
                                phase_next   = gdsrs_pkg::PH_WAIT;
                                after_next   = gdsrs_pkg::PH_IDLE;
                            end
                            else
                            begin
                                st_step_next  = gdsrs_pkg::ST_WAIT;
                                st_after_next = st_step_reg + 3'd1;
                            end
                        end
                    end
                    gdsrs_pkg::PH_CONTROL:
                    begin
                        if (ct_step_reg == gdsrs_pkg::CT_WAIT)
                        begin
                            if (wait_done)
                            begin
                                ct_step_next = ct_after_reg;
                            end
                        end
                        else
                        begin
                            ticks_next = '0;
                            wait_next  = gdsrs_pkg::SWITCH_DELAY;
                            if (ct_step_reg == gdsrs_pkg::CT_LAST)
                            begin
                                ct_step_next = '0;
                                phase_next   = gdsrs_pkg::PH_WAIT;
                                after_next   = gdsrs_pkg::PH_IDLE;
                            end
                            else
                            begin
                                ct_step_next  = gdsrs_pkg::CT_WAIT;
                                ct_after_next = ct_step_reg + 3'd1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                // unused mode code: no change
            end
        endcase
    end

    // result of this step
    always_comb
    begin
        result              = '0;
        result.drive_enable = drive_next;
        if (is_poll && st_access)
        begin
            result.access_valid = 1'b1;
            result.reg_slot     = {1'b0, st_step_reg};
            result.spi_command  = {1'b1, gdsrs_pkg::slot_address({1'b0, st_step_reg}), 11'd0};
            result.reg_value    = item.spi_reply[10:0] & gdsrs_pkg::DATA_MASK;
        end
        else if (is_poll && ct_access)
        begin
            result.access_valid = 1'b1;
            result.reg_slot     = gdsrs_pkg::CTRL_BASE + {1'b0, ct_step_reg};
            result.spi_command  = {1'b0,
                                   gdsrs_pkg::slot_address(gdsrs_pkg::CTRL_BASE
                                                           + {1'b0, ct_step_reg}),
                                   ctrl_word};
            result.reg_value    = item.spi_reply[10:0] & gdsrs_pkg::DATA_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= gdsrs_pkg::PH_INIT;
            after_reg    <= gdsrs_pkg::PH_INIT;
            st_step_reg  <= '0;
            st_after_reg <= '0;
            ct_step_reg  <= '0;
            ct_after_reg <= '0;
            ticks_reg    <= '0;
            wait_reg     <= '0;
            drive_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            after_reg    <= after_next;
            st_step_reg  <= st_step_next;
            st_after_reg <= st_after_next;
            ct_step_reg  <= ct_step_next;
            ct_after_reg <= ct_after_next;
            ticks_reg    <= ticks_next;
            wait_reg     <= wait_next;
            drive_reg    <= drive_next;
        end
    end

endmodule

// ----- src/gate_driver_spi_register_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_driver_spi_register_sequencer
// Timed SPI frame sequencer for a gate-driver chip: poll steps, timer ticks
// and reprogram requests in, one frame/status result out per transaction.
// ----------------------------------------------------------------------------
// usage
//   in channel  (in_valid/in_ready, in_item): one poll step, tick or confirm
//   out channel (out_valid/out_ready, out_item): exactly one result per input
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): control words 0-6
//     and the poll interval at index 7; cfg_ready is always high, write only
//     while the block is idle
// output: the result is registered and appears in the cycle after its input transaction
// throughput: one transaction per cycle while the output is not stalled; the whole step is one pass of
//   phase/sub-step logic between the sequencer state and the result register
// stall: while out_valid is high and out_ready low the result register holds
//   and in_ready drops; in_ready follows out_ready in the same cycle, so a
//   draining output keeps full rate
// reset: phase goes to init, drive enable low, timer cleared, control words
//   zero, poll interval 100; no clearing pass is needed
// ----------------------------------------------------------------------------
module gate_driver_spi_register_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gdsrs_pkg::in_item_t   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gdsrs_pkg::out_item_t  out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    logic                 out_valid_reg, out_valid_next;
    gdsrs_pkg::out_item_t out_item_reg;
    gdsrs_pkg::out_item_t step_result;
    logic                 accept;
    logic [2:0]           ctrl_index;
    logic [10:0]          ctrl_word;
    logic [15:0]          poll_interval;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    gdsrs_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (cfg_valid && cfg_ready),
        .wr_index      (cfg_index),
        .wr_data       (cfg_data),
        .rd_index      (ctrl_index),
        .ctrl_word     (ctrl_word),
        .poll_interval (poll_interval)
    );

    gdsrs_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (accept),
        .item          (in_item),
        .ctrl_word     (ctrl_word),
        .poll_interval (poll_interval),
        .ctrl_index    (ctrl_index),
        .result        (step_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload register, loaded on each input transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- sim/tb_gate_driver_spi_register_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gate_driver_spi_register_sequencer
// Self-checking bench for the gate-driver SPI sequencer: drives poll steps,
// ticks and reprogram requests over several register settings, predicts each
// frame from a behavioral copy of the sequencer and checks every result.
// ----------------------------------------------------------------------------
module tb_gate_driver_spi_register_sequencer;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // chip address of slots 0..10, four bits each, slot 0 in the low nibble
    localparam logic [43:0] CHIP_ADDR = {4'd12, 4'd11, 4'd10, 4'd9, 4'd7, 4'd6,
                                         4'd5, 4'd4, 4'd3, 4'd2, 4'd1};

    typedef enum int {
        WORDS_ZERO,
        WORDS_FULL,
        WORDS_RANDOM
    } word_fill_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    gdsrs_pkg::in_item_t  in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    gdsrs_pkg::out_item_t out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    logic quiet = 1'b0;
    int   steps_sent = 0;
    int   setting_phases = 0;

    gate_driver_spi_register_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // sequencer tracker: mirrors the frame sequencing and checks results
    // ------------------------------------------------------------------------
    class spi_frame_tracker;
        logic [10:0]          ctrl_word [7];
        logic [15:0]          poll_ivl;
        gdsrs_pkg::phase_t    phase;
        gdsrs_pkg::phase_t    after_main;
        logic [2:0]           st_step;
        logic [2:0]           st_after;
        logic [2:0]           ct_step;
        logic [2:0]           ct_after;
        logic [15:0]          ticks;
        logic [15:0]          wait_len;
        logic                 drive;
        gdsrs_pkg::out_item_t expected_frames[$];
        int                   failures;
        int                   status_reads;
        int                   control_writes;
        int                   reg_writes;

        function new();
            foreach (ctrl_word[i])
                ctrl_word[i] = '0;
            poll_ivl = gdsrs_pkg::POLL_RESET;
            phase = gdsrs_pkg::PH_INIT;
            after_main = gdsrs_pkg::PH_INIT;
            st_step = '0;
            st_after = '0;
            ct_step = '0;
            ct_after = '0;
            ticks = '0;
            wait_len = '0;
            drive = 1'b0;
            failures = 0;
            status_reads = 0;
            control_writes = 0;
            reg_writes = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            if (idx == gdsrs_pkg::CFG_POLL)
                poll_ivl = data;
            else
                ctrl_word[idx] = data[10:0];
            reg_writes++;
        endfunction

        function void go_main(gdsrs_pkg::phase_t nxt, logic [15:0] len);
            ticks = '0;
            phase = gdsrs_pkg::PH_WAIT;
            after_main = nxt;
            wait_len = len;
        endfunction

        function void predict_frame(gdsrs_pkg::in_item_t it);
            gdsrs_pkg::out_item_t r;
            logic [3:0]           slot;
            r = '0;
            slot = '0;
            if (it.mode == gdsrs_pkg::MODE_TICK) begin
                if (ticks != '1)
                    ticks = ticks + 1'b1;
            end
            else if (it.mode == gdsrs_pkg::MODE_CONFIRM) begin
                go_main(gdsrs_pkg::PH_CONTROL, gdsrs_pkg::SWITCH_DELAY);
            end
            else if (it.mode == gdsrs_pkg::MODE_POLL) begin
                case (phase)
                    gdsrs_pkg::PH_INIT:
                    begin
                        drive = 1'b1;
                        go_main(gdsrs_pkg::PH_CONTROL, gdsrs_pkg::SWITCH_DELAY);
                    end
                    gdsrs_pkg::PH_IDLE:
                        if (ticks >= poll_ivl)
                            go_main(gdsrs_pkg::PH_STATUS, gdsrs_pkg::SWITCH_DELAY);
                    gdsrs_pkg::PH_WAIT:
                        if (ticks >= wait_len)
                            phase = after_main;
                    gdsrs_pkg::PH_STATUS:
                        if (st_step == gdsrs_pkg::ST_WAIT) begin
                            if (ticks >= wait_len)
                                st_step = st_after;
                        end
                        else begin
                            slot = {1'b0, st_step};
                            r.access_valid = 1'b1;
                            r.spi_command = {1'b1, CHIP_ADDR[slot*4 +: 4], 11'd0};
                            status_reads++;
                            if (st_step == gdsrs_pkg::ST_LAST) begin
                                st_step = '0;
                                go_main(gdsrs_pkg::PH_IDLE, gdsrs_pkg::STATUS_STEP_DELAY);
                            end
                            else begin
                                ticks = '0;
                                st_after = st_step + 1'b1;
                                st_step = gdsrs_pkg::ST_WAIT;
                                wait_len = gdsrs_pkg::STATUS_STEP_DELAY;
                            end
                        end
                    gdsrs_pkg::PH_CONTROL:
                        if (ct_step == gdsrs_pkg::CT_WAIT) begin
                            if (ticks >= wait_len)
                                ct_step = ct_after;
                        end
                        else begin
                            slot = gdsrs_pkg::CTRL_BASE + ct_step;
                            r.access_valid = 1'b1;
                            r.spi_command = {1'b0, CHIP_ADDR[slot*4 +: 4], ctrl_word[ct_step]};
                            control_writes++;
                            if (ct_step == gdsrs_pkg::CT_LAST) begin
                                ct_step = '0;
                                go_main(gdsrs_pkg::PH_IDLE, gdsrs_pkg::SWITCH_DELAY);
                            end
                            else begin
                                ticks = '0;
                                ct_after = ct_step + 1'b1;
                                ct_step = gdsrs_pkg::CT_WAIT;
                                wait_len = gdsrs_pkg::SWITCH_DELAY;
                            end
                        end
                    default: ;
                endcase
            end
            if (r.access_valid) begin
                r.reg_slot = slot;
                r.reg_value = it.spi_reply[10:0];
            end
            r.drive_enable = drive;
            expected_frames.push_back(r);
        endfunction

        function void compare(string name, logic [15:0] exp, logic [15:0] got);
            if (got !== exp) begin
                $error("%s mismatch: expected %0h, actual %0h", name, exp, got);
                failures++;
            end
        endfunction

        function void check_frame(gdsrs_pkg::out_item_t got);
            gdsrs_pkg::out_item_t exp;
            if (expected_frames.size() == 0) begin
                $error("unexpected result transaction %0h", got);
                failures++;
                return;
            end
            exp = expected_frames.pop_front();
            compare("access_valid", exp.access_valid, got.access_valid);
            compare("spi_command", exp.spi_command, got.spi_command);
            compare("reg_slot", exp.reg_slot, got.reg_slot);
            compare("reg_value", exp.reg_value, got.reg_value);
            compare("drive_enable", exp.drive_enable, got.drive_enable);
        endfunction
    endclass

    spi_frame_tracker tracker = new();

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watch all three channels
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                tracker.check_frame(out_item);
            if (in_valid && in_ready)
                tracker.predict_frame(in_item);
            if (cfg_valid && cfg_ready)
                tracker.set_reg(cfg_index, cfg_data);
        end
    end

    // result side back-pressure
    always @(posedge clk)
        out_ready <= !(!quiet && $urandom_range(0, 99) < 11);

    function automatic logic [15:0] pick_reply();
        logic [1:0] k;
        k = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0)
            return 16'($urandom_range(0, 65535));
        case (k)
            2'd0:    return 16'h0000;
            2'd1:    return 16'hFFFF;
            2'd2:    return 16'h07FF;
            default: return 16'hF800;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] m, input logic [15:0] reply);
        while (!quiet && $urandom_range(0, 99) < 11) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item.mode <= m;
        in_item.spi_reply <= reply;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (m != MODE_UNUSED)
            steps_sent++;
    endtask

    task automatic tick_run(input int n);
        repeat (n)
            send_item(gdsrs_pkg::MODE_TICK, pick_reply());
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (tracker.expected_frames.size() != 0 && guard < 1000) begin
            @(posedge clk);
            guard++;
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic load_settings(input word_fill_t fill, input logic [15:0] poll);
        logic [15:0] data;
        for (int i = 0; i < 8; i++) begin
            if (gdsrs_pkg::cfg_index_t'(i) == gdsrs_pkg::CFG_POLL)
                data = poll;
            else if (fill == WORDS_ZERO)
                data = 16'h0000;
            else if (fill == WORDS_FULL)
                data = 16'hFFFF;
            else
                data = 16'($urandom_range(0, 65535));
            cfg_valid <= 1'b1;
            cfg_index <= gdsrs_pkg::cfg_index_t'(i);
            cfg_data <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        setting_phases++;
    endtask

    // mostly tick runs and polls, with rare reprograms and unused codes
    task automatic random_items(input int n);
        int start;
        int pick;
        start = steps_sent;
        while (steps_sent - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_item(gdsrs_pkg::MODE_CONFIRM, pick_reply());
            else if (pick < 6)
                send_item(MODE_UNUSED, pick_reply());
            else if (pick < 50)
                tick_run($urandom_range(1, 12));
            else
                send_item(gdsrs_pkg::MODE_POLL, pick_reply());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(WORDS_RANDOM, 16'd3);
        // directed opening: unused code and a tick before the drive comes up
        send_item(MODE_UNUSED, 16'hFFFF);
        send_item(gdsrs_pkg::MODE_TICK, 16'h0000);
        send_item(gdsrs_pkg::MODE_POLL, 16'h07FF);
        send_item(gdsrs_pkg::MODE_POLL, 16'h0800);
        send_item(gdsrs_pkg::MODE_CONFIRM, 16'hFFFF);
        for (int i = 0; i < 10; i++)
            send_item(gdsrs_pkg::MODE_TICK, (i % 2) ? 16'hAAAA : 16'h5555);
        send_item(gdsrs_pkg::MODE_POLL, 16'h0000);
        send_item(gdsrs_pkg::MODE_POLL, 16'hFFFF);
        // reprogram while the control writes are under way
        send_item(gdsrs_pkg::MODE_CONFIRM, 16'h0000);
        send_item(MODE_UNUSED, 16'h0000);
        tick_run(10);
        send_item(gdsrs_pkg::MODE_POLL, 16'hF800);
        send_item(gdsrs_pkg::MODE_POLL, 16'h07FF);
        random_items(400);
        settle();

        load_settings(WORDS_ZERO, 16'd0);
        random_items(400);
        settle();

        quiet = 1'b1;
        load_settings(WORDS_FULL, 16'd1);
        random_items(400);
        settle();
        quiet = 1'b0;

        load_settings(WORDS_RANDOM, 16'($urandom_range(2, 40)));
        random_items(400);
        settle();

        // longest poll interval, so the status round stays out of reach
        load_settings(WORDS_RANDOM, 16'hFFFF);
        tick_run(40);
        random_items(60);
        settle();

        if (tracker.expected_frames.size() != 0) begin
            $error("%0d expected results never arrived", tracker.expected_frames.size());
            tracker.failures++;
        end
        $display("covered %0d steps over %0d register settings (%0d register writes)",
                 steps_sent, setting_phases, tracker.reg_writes);
        $display("frames checked: %0d status reads, %0d control writes",
                 tracker.status_reads, tracker.control_writes);
        if (tracker.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
